[rtl/core/huber_loss_and_gradient_macros.svh]
// Assertion macros for the Huber loss block.
// Used by the controller and the divider; expects clk_i and rst_ni in scope.
`ifndef HUBER_LOSS_AND_GRADIENT_MACROS_SVH
`define HUBER_LOSS_AND_GRADIENT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define HLG_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define HLG_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/hlg_pkg.sv]
// Shared widths, constants and controller/datapath interface types
// for the Huber loss block. No dependencies.
`timescale 1ns / 1ps

package hlg_pkg;

  localparam int DATA_W     = 32;                       // prediction, target, gradient
  localparam int DELTA_W    = 31;
  localparam int BLEN_W     = 21;
  localparam int LOSS_W     = 48;
  localparam int SUM_W      = 64;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DELTA_W;
  localparam int MAX_BATCH  = 1048576;
  localparam int BCNT_W     = $clog2(MAX_BATCH + 1);
  localparam int LOSS_SHIFT = 17;                       // Q16.16 product plus the factor one half
  localparam int OPA_W      = DATA_W + 1;
  localparam int PROD_W     = OPA_W + DATA_W;
  localparam int STEP_W     = $clog2(SUM_W + 1);
  localparam int GRAD_STEPS = DELTA_W;
  localparam int MEAN_STEPS = SUM_W;
  localparam logic [DELTA_W-1:0] DELTA_RST = DELTA_W'(65536);
  localparam logic [BLEN_W-1:0]  BLEN_RST  = BLEN_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELTA = 1'b0,
    CFG_BLEN  = 1'b1
  } hlg_cfg_e;

  typedef struct packed {
    logic capture;
    logic prep;
    logic sel;
    logic mul;
    logic acc;
    logic div_go;
    logic div_mean;
    logic grad_take;
    logic mean_take;
    logic out_load;
  } hlg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
  } hlg_sts_t;

endpackage

[rtl/core/hlg_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, variable step count.
// Depends on hlg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "huber_loss_and_gradient_macros.svh"

module hlg_div import hlg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [BCNT_W-1:0] divisor_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic              done_o,
  output logic [SUM_W-1:0]  quotient_o
);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [SUM_W-1:0]  quo_q;
  logic [BCNT_W-1:0] rem_q;
  logic [BCNT_W-1:0] den_q;

  logic [BCNT_W:0] shifted;
  logic [BCNT_W:0] trial;
  logic            ge;

  // dividend bits enter the partial remainder from the top of quo_q
  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], ge};
      rem_q <= ge ? trial[BCNT_W-1:0] : shifted[BCNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  `HLG_ASSERT_IMP(a_go_when_idle, go_i, !busy_q, "divider started while busy")
  `HLG_ASSERT_IMP(a_done_after_busy, done_q, $past(busy_q) && !busy_q, "done without a run")
  `HLG_ASSERT_IMP(a_busy_count, busy_q, cnt_q != '0, "divider busy with zero steps left")

endmodule

[rtl/core/hlg_dp.sv]
// Datapath: config registers, difference and clamp, loss multiplier,
// batch and running totals, output registers. Uses hlg_pkg and hlg_div.
`timescale 1ns / 1ps

module hlg_dp import hlg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [DATA_W-1:0]     prediction_i,
  input  logic [DATA_W-1:0]     target_i,
  input  logic                  last_i,
  input  hlg_cmd_t              cmd_i,
  output hlg_sts_t              sts_o,
  output logic [DATA_W-1:0]     gradient_o,
  output logic [LOSS_W-1:0]     element_loss_o,
  output logic                  mean_valid_o,
  output logic [LOSS_W-1:0]     batch_mean_o,
  output logic [SUM_W-1:0]      running_sum_o,
  output logic [CNT_W-1:0]      running_count_o,
  output logic                  saturated_o
);

  // configuration
  logic [DELTA_W-1:0] delta_q;
  logic [BLEN_W-1:0]  blen_q;
  logic [BCNT_W-1:0]  blen_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= DELTA_RST;
      blen_q  <= BLEN_RST;
    end else if (cfg_we_i) begin
      unique case (hlg_cfg_e'(cfg_idx_i))
        CFG_DELTA: delta_q <= cfg_wdata_i[DELTA_W-1:0];
        CFG_BLEN:  blen_q  <= cfg_wdata_i[BLEN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    if (blen_q == '0) begin
      blen_eff = BCNT_W'(1);
    end else if (BCNT_W'(blen_q) > BCNT_W'(MAX_BATCH)) begin
      blen_eff = BCNT_W'(MAX_BATCH);
    end else begin
      blen_eff = BCNT_W'(blen_q);
    end
  end

  // item and work registers
  logic [DATA_W-1:0]  pred_q, targ_q;
  logic               last_q;
  logic               dneg_q;
  logic [DATA_W-1:0]  a_q;
  logic               sat_q;
  logic [DELTA_W-1:0] mag_q;
  logic [OPA_W-1:0]   opa_q;
  logic [DATA_W-1:0]  opb_q;
  logic [PROD_W-1:0]  prod_q;
  logic [LOSS_W-1:0]  loss_q;
  logic [DATA_W-1:0]  grad_q;
  logic [LOSS_W-1:0]  mean_q;

  // batch and running state
  logic [SUM_W-1:0]  bsum_q, tsum_q;
  logic [BCNT_W-1:0] bcnt_q;
  logic [CNT_W-1:0]  tcnt_q;

  // difference, saturated to 32 bits, and its magnitude
  logic [DATA_W:0]   diff;
  logic              ovf;
  logic [DATA_W-1:0] d;
  logic [DATA_W-1:0] a;

  assign diff = {pred_q[DATA_W-1], pred_q} - {targ_q[DATA_W-1], targ_q};
  assign ovf  = diff[DATA_W] ^ diff[DATA_W-1];
  always_comb begin
    if (ovf) begin
      d = diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      d = diff[DATA_W-1:0];
    end
    a = d[DATA_W-1] ? (~d + DATA_W'(1)) : d;
  end

  // quadratic or linear region; operands for a*a or (2a - delta)*delta
  logic              le;
  logic [OPA_W-1:0]  lin_opa;
  assign le      = a_q <= {1'b0, delta_q};
  assign lin_opa = {a_q, 1'b0} - {2'b00, delta_q};

  logic [PROD_W-1:0] prod;
  assign prod = opa_q * opb_q;

  logic [LOSS_W-1:0] loss;
  assign loss = prod_q[LOSS_SHIFT +: LOSS_W];

  // totals
  logic [SUM_W:0] bsum_add, tsum_add;
  assign bsum_add = {1'b0, bsum_q} + {{(SUM_W-LOSS_W+1){1'b0}}, loss};
  assign tsum_add = {1'b0, tsum_q} + {{(SUM_W-LOSS_W+1){1'b0}}, loss};

  // divider
  logic [SUM_W-1:0]  div_dividend;
  logic [BCNT_W-1:0] div_divisor;
  logic [STEP_W-1:0] div_steps;
  logic              div_done;
  logic [SUM_W-1:0]  quo;

  always_comb begin
    if (cmd_i.div_mean) begin
      div_dividend = bsum_q;
      div_divisor  = bcnt_q;
      div_steps    = STEP_W'(MEAN_STEPS);
    end else begin
      // magnitude left-aligned so the quotient lands in the low bits
      div_dividend = {mag_q, {(SUM_W-DELTA_W){1'b0}}};
      div_divisor  = blen_eff;
      div_steps    = STEP_W'(GRAD_STEPS);
    end
  end

  hlg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.div_go),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  logic [DATA_W-1:0] gq;
  assign gq = {{(DATA_W-DELTA_W){1'b0}}, quo[DELTA_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsum_q <= '0;
      bcnt_q <= '0;
      tsum_q <= '0;
      tcnt_q <= '0;
    end else if (cmd_i.acc) begin
      bsum_q <= bsum_add[SUM_W] ? '1 : bsum_add[SUM_W-1:0];
      tsum_q <= tsum_add[SUM_W] ? '1 : tsum_add[SUM_W-1:0];
      if (bcnt_q < BCNT_W'(MAX_BATCH)) begin
        bcnt_q <= bcnt_q + BCNT_W'(1);
      end
      if (tcnt_q != '1) begin
        tcnt_q <= tcnt_q + CNT_W'(1);
      end
    end else if (cmd_i.mean_take) begin
      bsum_q <= '0;
      bcnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pred_q <= prediction_i;
      targ_q <= target_i;
      last_q <= last_i;
      mean_q <= '0;
    end
    if (cmd_i.prep) begin
      dneg_q <= d[DATA_W-1];
      a_q    <= a;
      sat_q  <= ovf;
    end
    if (cmd_i.sel) begin
      mag_q <= le ? a_q[DELTA_W-1:0] : delta_q;
      opa_q <= le ? {1'b0, a_q} : lin_opa;
      opb_q <= le ? a_q : {1'b0, delta_q};
    end
    if (cmd_i.mul) begin
      prod_q <= prod;
    end
    if (cmd_i.acc) begin
      loss_q <= loss;
      if (bsum_add[SUM_W] || tsum_add[SUM_W] || (bcnt_q >= BCNT_W'(MAX_BATCH)) ||
          (tcnt_q == '1)) begin
        sat_q <= 1'b1;
      end
    end
    if (cmd_i.grad_take) begin
      grad_q <= dneg_q ? (~gq + DATA_W'(1)) : gq;
    end
    if (cmd_i.mean_take) begin
      if (|quo[SUM_W-1:LOSS_W]) begin
        mean_q <= '1;
        sat_q  <= 1'b1;
      end else begin
        mean_q <= quo[LOSS_W-1:0];
      end
    end
    if (cmd_i.out_load) begin
      gradient_o      <= grad_q;
      element_loss_o  <= loss_q;
      mean_valid_o    <= last_q;
      batch_mean_o    <= mean_q;
      running_sum_o   <= tsum_q;
      running_count_o <= tcnt_q;
      saturated_o     <= sat_q;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.last     = last_q;

endmodule

[rtl/core/hlg_ctrl.sv]
// Controller state machine: sequences one item through the datapath and
// owns both handshakes. Uses hlg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "huber_loss_and_gradient_macros.svh"

module hlg_ctrl import hlg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  hlg_sts_t sts_i,
  output hlg_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEL,
    ST_MUL,
    ST_ACC,
    ST_GDIV,
    ST_MGO,
    ST_MDIV,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && in_ready_q;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = accept;
    cmd_o.prep      = (state_q == ST_PREP);
    cmd_o.sel       = (state_q == ST_SEL);
    cmd_o.mul       = (state_q == ST_MUL);
    cmd_o.acc       = (state_q == ST_ACC);
    cmd_o.div_go    = (state_q == ST_ACC) || (state_q == ST_MGO);
    cmd_o.div_mean  = (state_q == ST_MGO);
    cmd_o.grad_take = (state_q == ST_GDIV) && sts_i.div_done;
    cmd_o.mean_take = (state_q == ST_MDIV) && sts_i.div_done;
    cmd_o.out_load  = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          in_ready_q <= 1'b1;
          if (accept) begin
            in_ready_q <= 1'b0;
            state_q    <= ST_PREP;
          end
        end
        ST_PREP: state_q <= ST_SEL;
        ST_SEL:  state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_ACC;
        ST_ACC:  state_q <= ST_GDIV;
        ST_GDIV: begin
          if (sts_i.div_done) begin
            state_q <= sts_i.last ? ST_MGO : ST_OUT;
          end
        end
        ST_MGO:  state_q <= ST_MDIV;
        ST_MDIV: begin
          if (sts_i.div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  `HLG_ASSERT_IMP(a_ready_only_idle, in_ready_q, state_q == ST_IDLE, "ready outside idle")
  `HLG_ASSERT_NXT(a_accept_starts, accept, (state_q == ST_PREP) && !in_ready_q,
                  "accepted item did not start")
  `HLG_ASSERT_IMP(a_done_in_wait, sts_i.div_done,
                  (state_q == ST_GDIV) || (state_q == ST_MDIV), "divider done out of place")
  `HLG_ASSERT_IMP(a_mean_on_last, state_q == ST_MGO, sts_i.last, "mean divide without last")

endmodule

[rtl/core/huber_loss_and_gradient.sv]
// Channel   | Handshake                | Payload
// ----------+--------------------------+-------------------------------------------
// input     | in_valid_i / in_ready_o  | prediction_i, target_i, last_i
// result    | out_valid_o / out_ready_i| gradient_o, element_loss_o, mean_valid_o,
//           |                          | batch_mean_o, running_sum_o, running_count_o,
//           |                          | saturated_o
// config    | cfg_we_i (no wait)       | cfg_idx_i, cfg_wdata_i
//
// One item at a time, the pace set by the radix-2 divider: 31 steps for the gradient
// and 64 more for the batch mean of an item flagged last, one quotient bit per cycle.
// Asynchronous active-low reset, no clearing pass; ready rises in the cycle after it.
// A result waiting in the output register does not block the next item; a stalled
// result holds the finished item in the final state until the register frees.
// Top level; depends on hlg_pkg, hlg_ctrl and hlg_dp.
`timescale 1ns / 1ps

module huber_loss_and_gradient import hlg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_W-1:0]     prediction_i,
  input  logic [DATA_W-1:0]     target_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_W-1:0]     gradient_o,
  output logic [LOSS_W-1:0]     element_loss_o,
  output logic                  mean_valid_o,
  output logic [LOSS_W-1:0]     batch_mean_o,
  output logic [SUM_W-1:0]      running_sum_o,
  output logic [CNT_W-1:0]      running_count_o,
  output logic                  saturated_o
);

  hlg_cmd_t cmd;
  hlg_sts_t sts;

  hlg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hlg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .prediction_i    (prediction_i),
    .target_i        (target_i),
    .last_i          (last_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .gradient_o      (gradient_o),
    .element_loss_o  (element_loss_o),
    .mean_valid_o    (mean_valid_o),
    .batch_mean_o    (batch_mean_o),
    .running_sum_o   (running_sum_o),
    .running_count_o (running_count_o),
    .saturated_o     (saturated_o)
  );

endmodule

[tb/sv/huber_loss_checker.sv]
// Result checker for huber_loss_and_gradient: tracks register writes, predicts every
// accepted item and compares each accepted result with the oldest prediction.
// Depends on hlg_pkg.
`timescale 1ns / 1ps

module huber_loss_checker import hlg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [DATA_W-1:0]     prediction_i,
  input  logic [DATA_W-1:0]     target_i,
  input  logic                  last_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [DATA_W-1:0]     gradient_i,
  input  logic [LOSS_W-1:0]     element_loss_i,
  input  logic                  mean_valid_i,
  input  logic [LOSS_W-1:0]     batch_mean_i,
  input  logic [SUM_W-1:0]      running_sum_i,
  input  logic [CNT_W-1:0]      running_count_i,
  input  logic                  saturated_i,
  output int unsigned           n_fail_o,
  output int unsigned           n_pending_o,
  output int unsigned           n_results_o,
  output int unsigned           n_means_o,
  output int unsigned           n_sat_o
);

  localparam longint DIFF_MAX = 64'sd2147483647;
  localparam longint DIFF_MIN = -64'sd2147483648;
  localparam logic [63:0] MEAN_MAX = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [DATA_W-1:0] gradient;
    logic [LOSS_W-1:0] loss;
    logic              mean_valid;
    logic [LOSS_W-1:0] mean;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  count;
    logic              sat;
  } huber_result_t;

  logic [DELTA_W-1:0] delta_q;
  logic [BLEN_W-1:0]  blen_q;
  logic [SUM_W-1:0]   batch_sum_q;
  logic [BCNT_W-1:0]  batch_cnt_q;
  logic [SUM_W-1:0]   total_sum_q;
  logic [CNT_W-1:0]   total_cnt_q;

  huber_result_t expected_q[$];
  int unsigned   n_fail, n_results, n_means, n_sat;

  // {carry, sum}; the sum sticks at all ones on carry
  function automatic logic [SUM_W:0] add_clip(input logic [SUM_W-1:0] a,
                                              input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[SUM_W]) s[SUM_W-1:0] = '1;
    return s;
  endfunction

  // Works out one result and advances the batch and running totals.
  function automatic huber_result_t predict_huber(input logic [DATA_W-1:0] pred,
                                                  input logic [DATA_W-1:0] tgt,
                                                  input logic              last);
    huber_result_t  r;
    longint         diff, clip;
    logic [63:0]    mag, dl, loss, divisor, quo, cnt, mean;
    logic [SUM_W:0] s;
    logic           sat;
    sat  = 1'b0;
    diff = longint'($signed(pred)) - longint'($signed(tgt));
    if (diff > DIFF_MAX) begin
      diff = DIFF_MAX;
      sat  = 1'b1;
    end
    if (diff < DIFF_MIN) begin
      diff = DIFF_MIN;
      sat  = 1'b1;
    end
    mag = (diff < 0) ? -diff : diff;
    dl  = 64'(delta_q);
    if (mag <= dl) loss = (mag * mag) >> LOSS_SHIFT;
    else           loss = ((2 * mag - dl) * dl) >> LOSS_SHIFT;

    clip = diff;
    if (clip > longint'(dl))  clip = longint'(dl);
    if (clip < -longint'(dl)) clip = -longint'(dl);
    if (blen_q == '0)              divisor = 64'd1;
    else if (blen_q > MAX_BATCH)   divisor = 64'(MAX_BATCH);
    else                           divisor = 64'(blen_q);
    mag = (clip < 0) ? -clip : clip;
    quo = mag / divisor;
    r.gradient = (clip < 0) ? DATA_W'(-quo) : DATA_W'(quo);

    s = add_clip(batch_sum_q, loss);
    batch_sum_q = s[SUM_W-1:0];
    sat |= s[SUM_W];
    if (batch_cnt_q < MAX_BATCH) batch_cnt_q = batch_cnt_q + 1'b1;
    else                         sat = 1'b1;
    s = add_clip(total_sum_q, loss);
    total_sum_q = s[SUM_W-1:0];
    sat |= s[SUM_W];
    if (total_cnt_q != '1) total_cnt_q = total_cnt_q + 1'b1;
    else                   sat = 1'b1;

    mean = '0;
    if (last) begin
      cnt  = (batch_cnt_q == '0) ? 64'd1 : 64'(batch_cnt_q);
      mean = batch_sum_q / cnt;
      if (mean > MEAN_MAX) begin
        mean = MEAN_MAX;
        sat  = 1'b1;
      end
      batch_sum_q = '0;
      batch_cnt_q = '0;
    end

    r.loss       = loss[LOSS_W-1:0];
    r.mean_valid = last;
    r.mean       = mean[LOSS_W-1:0];
    r.sum        = total_sum_q;
    r.count      = total_cnt_q;
    r.sat        = sat;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    huber_result_t got, want;
    if (!rst_ni) begin
      delta_q     = DELTA_RST;
      blen_q      = BLEN_RST;
      batch_sum_q = '0;
      batch_cnt_q = '0;
      total_sum_q = '0;
      total_cnt_q = '0;
      expected_q.delete();
      n_fail      = 0;
      n_results   = 0;
      n_means     = 0;
      n_sat       = 0;
    end else begin
      if (cfg_we_i) begin
        case (hlg_cfg_e'(cfg_idx_i))
          CFG_DELTA: delta_q = cfg_wdata_i[DELTA_W-1:0];
          CFG_BLEN:  blen_q  = cfg_wdata_i[BLEN_W-1:0];
          default: ;
        endcase
      end

      // results first: a result can never belong to an item taken at the same edge
      if (out_valid_i && out_ready_i) begin
        got.gradient   = gradient_i;
        got.loss       = element_loss_i;
        got.mean_valid = mean_valid_i;
        got.mean       = batch_mean_i;
        got.sum        = running_sum_i;
        got.count      = running_count_i;
        got.sat        = saturated_i;
        n_results++;
        if (mean_valid_i) n_means++;
        if (saturated_i)  n_sat++;
        if (expected_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("[%0t] result %0d arrived with no item outstanding", $time, n_results);
        end else begin
          want = expected_q.pop_front();
          if (want.gradient !== got.gradient || want.loss !== got.loss ||
              want.mean_valid !== got.mean_valid || want.mean !== got.mean ||
              want.sum !== got.sum || want.count !== got.count || want.sat !== got.sat) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("[%0t] mismatch on result %0d", $time, n_results);
              $display("  exp grad=%h loss=%h mv=%b mean=%h sum=%h cnt=%h sat=%b",
                       want.gradient, want.loss, want.mean_valid, want.mean,
                       want.sum, want.count, want.sat);
              $display("  got grad=%h loss=%h mv=%b mean=%h sum=%h cnt=%h sat=%b",
                       got.gradient, got.loss, got.mean_valid, got.mean,
                       got.sum, got.count, got.sat);
            end
          end
        end
      end

      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_huber(prediction_i, target_i, last_i));
    end

    n_fail_o    <= n_fail;
    n_pending_o <= expected_q.size();
    n_results_o <= n_results;
    n_means_o   <= n_means;
    n_sat_o     <= n_sat;
  end

endmodule

[tb/sv/huber_loss_and_gradient_tb.sv]
// Testbench top for huber_loss_and_gradient: clock, reset, register settings, item
// and result traffic, verdict. Depends on hlg_pkg, the block and huber_loss_checker.
`timescale 1ns / 1ps

module huber_loss_and_gradient_tb;
  import hlg_pkg::*;

  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int IDLE_PCT        = 27;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 110;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [DATA_W-1:0]     prediction_i;
  logic [DATA_W-1:0]     target_i;
  logic                  last_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [DATA_W-1:0]     gradient_o;
  logic [LOSS_W-1:0]     element_loss_o;
  logic                  mean_valid_o;
  logic [LOSS_W-1:0]     batch_mean_o;
  logic [SUM_W-1:0]      running_sum_o;
  logic [CNT_W-1:0]      running_count_o;
  logic                  saturated_o;

  int unsigned n_fail, n_pending, n_results, n_means, n_sat;
  int unsigned n_sent     = 0;
  int unsigned n_settings = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done  = 0;
  bit          tx_idle_en;
  bit          rx_idle_en;
  logic [DELTA_W-1:0] cur_delta;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  huber_loss_and_gradient dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .prediction_i, .target_i, .last_i,
    .out_valid_o, .out_ready_i, .gradient_o, .element_loss_o, .mean_valid_o,
    .batch_mean_o, .running_sum_o, .running_count_o, .saturated_o
  );

  huber_loss_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i (in_ready_o), .prediction_i, .target_i, .last_i,
    .out_valid_i (out_valid_o), .out_ready_i,
    .gradient_i (gradient_o), .element_loss_i (element_loss_o),
    .mean_valid_i (mean_valid_o), .batch_mean_i (batch_mean_o),
    .running_sum_i (running_sum_o), .running_count_i (running_count_o),
    .saturated_i (saturated_o),
    .n_fail_o (n_fail), .n_pending_o (n_pending), .n_results_o (n_results),
    .n_means_o (n_means), .n_sat_o (n_sat)
  );

  // Result side: random ready, plus a long hold-off whenever one is asked for.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_done) begin
        hold_done++;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= !(rx_idle_en && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_item(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] t,
                           input logic l);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    prediction_i <= p;
    target_i     <= t;
    last_i       <= l;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
  endtask

  // Both registers, back to back; junk above bit 20 of the length must be ignored.
  task automatic write_regs(input logic [DELTA_W-1:0] dl, input logic [BLEN_W-1:0] bl);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DELTA;
    cfg_wdata_i <= dl;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BLEN;
    cfg_wdata_i <= {junk[CFG_DATA_W-1:BLEN_W], bl};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_delta   = dl;
    n_settings++;
  endtask

  function automatic logic [DATA_W-1:0] corner_value(input int unsigned k);
    case (k)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0]  p, t;
    logic               l;
    logic [DELTA_W-1:0] dl;
    logic [BLEN_W-1:0]  bl;
    logic [31:0]        span;
    longint             off;
    int unsigned        bsize, sent, n_directed;
    bit                 broken;

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_DELTA;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    prediction_i <= '0;
    target_i     <= '0;
    last_i       <= 1'b0;
    tx_idle_en   <= 1'b1;
    rx_idle_en   <= 1'b1;
    cur_delta    = DELTA_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: delta 1.0, length 1. Quadratic, edge of delta, linear, overflow.
    send_item(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_item(32'h0000_8000, 32'h0000_0000, 1'b0);
    send_item(32'h0001_0000, 32'h0000_0000, 1'b0);
    send_item(32'h0001_0001, 32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 32'h0003_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_item(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    drain();
    // zero delta, zero length
    write_regs('0, '0);
    send_item(32'h1234_5678, 32'h0000_0000, 1'b0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    drain();
    // widest delta, length beyond the batch limit
    write_regs('1, '1);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_item(32'h4000_0000, 32'hC000_0000, 1'b1);
    send_item(32'h0000_0001, 32'h0000_0000, 1'b1);
    drain();
    // smallest delta, length at the batch limit
    write_regs(DELTA_W'(1), BLEN_W'(MAX_BATCH));
    send_item(32'h0000_0001, 32'h0000_0000, 1'b0);
    send_item(32'h0000_0002, 32'h0000_0000, 1'b0);
    send_item(32'h0000_0000, 32'h0000_0002, 1'b0);
    send_item(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
    drain();
    // gradient truncation toward zero, both signs
    write_regs(DELTA_W'(196608), BLEN_W'(3));
    send_item(32'h0000_0000, 32'h0001_0001, 1'b0);
    send_item(32'h0001_0001, 32'h0000_0000, 1'b0);
    send_item(32'h0000_5555, 32'h0000_5556, 1'b1);
    n_directed = n_sent;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          dl = DELTA_W'($urandom_range(32'h0004_0000, 1));
          bl = BLEN_W'($urandom_range(8, 1));
        end
        1: begin
          dl = DELTA_W'(65536 * $urandom_range(4, 1));
          bl = BLEN_W'($urandom_range(16, 1));
        end
        2: begin
          dl = DELTA_W'($urandom());
          bl = BLEN_W'($urandom());
        end
        3: begin
          dl = '1;
          bl = BLEN_W'(MAX_BATCH);
        end
        4: begin
          dl = DELTA_W'($urandom_range(255, 1));
          bl = BLEN_W'(1);
        end
        default: begin
          dl = DELTA_W'($urandom()) | 31'h4000_0000;
          bl = '0;
        end
      endcase
      write_regs(dl, bl);
      // phase 1 runs with no idling on either side; phase 2 fills the block up
      tx_idle_en <= (ph != 1);
      rx_idle_en <= (ph != 1);
      if (ph == 2) hold_asked <= hold_asked + 1;
      span = (cur_delta >= 31'h4000_0000) ? 32'hFFFF_FFFF : {cur_delta[29:0], 2'b00};

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        bsize  = $urandom_range(12, 1);
        broken = ($urandom_range(5) == 0);
        for (int i = 0; i < bsize; i++) begin
          p = $urandom();
          case ($urandom_range(9))
            0, 1, 2: t = $urandom();
            8: begin
              off = longint'(cur_delta) + longint'($urandom_range(2)) - 1;
              if ($urandom_range(1)) off = -off;
              t = p - off[DATA_W-1:0];
            end
            9: begin
              p = corner_value($urandom_range(4));
              t = corner_value($urandom_range(4));
            end
            default: begin
              off = longint'($urandom_range(span)) - 2 * longint'(cur_delta);
              t = p - off[DATA_W-1:0];
            end
          endcase
          l = broken ? 1'($urandom_range(1)) : (i == bsize - 1);
          send_item(p, t, l);
        end
        sent += bsize;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d items (%0d directed) over %0d register settings,", n_sent,
             n_directed, n_settings + 1);
    $display("with %0d batch means and %0d saturated results checked.", n_means, n_sat);
    if (n_fail == 0 && n_pending == 0) begin
      $display("** huber_loss_and_gradient: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", n_fail, n_pending);
      $display("** huber_loss_and_gradient: FAILED **");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("Timeout: %0d items sent, %0d results outstanding", n_sent, n_pending);
    $display("** huber_loss_and_gradient: FAILED **");
    $finish;
  end

endmodule
